@@ src/kth_largest_select_macros.svh @@
// Assertion macros used by the RTL that checks itself.
`ifndef KTH_LARGEST_SELECT_MACROS_SVH
`define KTH_LARGEST_SELECT_MACROS_SVH

`ifndef ASSERT_OFF
`define KLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KLS_ASSERT(label, prop, msg)
`define KLS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ src/kls_pkg.sv @@
package kls_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W     = $clog2(MAX_ITEMS);

  typedef enum logic {
    ST_LOAD,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ src/kls_cell.sv @@
module kls_cell (
  input  logic                              clk,
  input  kls_pkg::cell_ctrl_t               ctrl,
  input  logic signed [kls_pkg::VAL_W-1:0]  new_val,
  input  logic                              empty,
  input  logic signed [kls_pkg::VAL_W-1:0]  left_val,
  input  logic                              left_take,
  input  logic signed [kls_pkg::VAL_W-1:0]  right_val,
  output logic signed [kls_pkg::VAL_W-1:0]  val,
  output logic                              take
);
  import kls_pkg::*;

  // The row is kept in descending order; a new element lands in front of
  // the first smaller or empty cell and everything behind it moves back one.
  assign take = ctrl.insert && (empty || (new_val > val));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= right_val;
    end else if (take) begin
      val <= left_take ? left_val : new_val;
    end
  end

endmodule

@@ src/kth_largest_select.sv @@
// Selects the rank-th largest of a set of signed 32-bit values. Elements are
// loaded one per cycle (start high, busy low) into a row of compare cells that
// keeps them sorted as they arrive; the element with last high closes the set,
// and up to 1024 elements are kept, later ones being dropped. After the last
// transfer the block is busy while the row shifts toward its head, and the
// result then appears with done for exactly one cycle; the receiver cannot
// stall it, so it must take it in that cycle. If rank is zero or exceeds
// the element count, done comes in the cycle after the last transfer with
// bad_rank set, selected zero, and busy stays low. The rank register resets
// to 1 and may be written only while no selection is pending.
`include "kth_largest_select_macros.svh"

module kth_largest_select (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [kls_pkg::VAL_W-1:0]  value,
  input  logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kls_pkg::CNT_W-1:0]         cfg_data,
  output logic                              done,
  output logic signed [kls_pkg::VAL_W-1:0]  selected,
  output logic                              bad_rank
);
  import kls_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [CNT_W-1:0]         rank;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         n_total;
  logic [IDX_W-1:0]         remaining;
  logic                     accept;
  logic                     full;
  logic                     rank_bad;
  logic                     finish;
  cell_ctrl_t               ctrl;
  logic signed [VAL_W-1:0]  cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]     cell_take;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(MAX_ITEMS));
  assign n_total   = full ? count : count + CNT_W'(1);
  assign rank_bad  = (rank == '0) || (rank > n_total);
  assign finish    = (state == ST_SHIFT) && (remaining == '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && last && !rank_bad) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (remaining == '0) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state)
      ST_LOAD: begin
        ctrl.insert = accept && !full;
      end
      ST_SHIFT: begin
        busy       = 1'b1;
        ctrl.shift = (remaining != '0);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      rank  <= CNT_W'(1);
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        rank <= cfg_data;
      end
      if (accept) begin
        if (last) begin
          count <= '0;
        end else if (!full) begin
          count <= count + CNT_W'(1);
        end
      end
      done <= (accept && last && rank_bad) || finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      remaining <= IDX_W'(rank - CNT_W'(1));
    end else if (ctrl.shift) begin
      remaining <= remaining - IDX_W'(1);
    end
    if (finish) begin
      selected <= cell_val[0];
      bad_rank <= 1'b0;
    end else begin
      selected <= '0;
      bad_rank <= 1'b1;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_val;
    logic                    left_take;
    logic signed [VAL_W-1:0] right_val;
    logic                    empty;

    assign empty = (count <= CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_val  = '0;
      assign left_take = 1'b0;
    end else begin : g_body
      assign left_val  = cell_val[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    kls_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_val   (value),
      .empty     (empty),
      .left_val  (left_val),
      .left_take (left_take),
      .right_val (right_val),
      .val       (cell_val[i]),
      .take      (cell_take[i])
    );
  end

  `KLS_ASSERT(a_done_not_busy, done |-> !busy, "result shown while still busy")
  `KLS_ASSERT(a_finish_result, finish |=> done && !bad_rank, "shift end gave no good result")
  `KLS_ASSERT(a_bad_zero, done && bad_rank |-> selected == '0, "bad rank result not zero")
  `KLS_ASSERT(a_busy_from_last, $rose(busy) |-> $past(start && last), "busy without a last")
  `KLS_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !done && !busy, "activity after reset")

endmodule

@@ verif/tb_kth_largest_select.sv @@
module tb_kth_largest_select;
  timeunit 1ns;
  timeprecision 1ps;

  import kls_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int MAX_RANK = (1 << CNT_W) - 1;

  typedef logic signed [VAL_W-1:0] elem_t;

  typedef struct {
    elem_t selected;
    logic  bad_rank;
  } pick_t;

  localparam elem_t MOST_NEG = 32'sh8000_0000;
  localparam elem_t MOST_POS = 32'sh7fff_ffff;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  elem_t            value = '0;
  logic             last = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             done;
  elem_t            selected;
  logic             bad_rank;

  pick_t       pending_picks[$];
  elem_t       set_sorted[$];
  int unsigned set_count = 0;
  int unsigned rank_now = 1;
  int          idle_pct = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;

  kth_largest_select u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .selected  (selected),
    .bad_rank  (bad_rank)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Keeps the current set in ascending order, so the k-th largest sits at n - k.
  task automatic track_element(input elem_t v, input logic closes);
    int    pos;
    pick_t p;
    if (set_count < MAX_ITEMS) begin
      pos = set_sorted.size();
      while (pos > 0 && set_sorted[pos-1] > v) pos--;
      set_sorted.insert(pos, v);
      set_count++;
    end
    if (closes) begin
      if (rank_now == 0 || rank_now > set_count) begin
        p.selected = '0;
        p.bad_rank = 1'b1;
      end else begin
        p.selected = set_sorted[set_count - rank_now];
        p.bad_rank = 1'b0;
      end
      pending_picks.push_back(p);
      set_sorted.delete();
      set_count = 0;
    end
  endtask

  task automatic load_element(input elem_t v, input logic closes);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      value = $urandom;
      last  = 1'($urandom_range(1));
    end
    @(negedge clk);
    start = 1'b1;
    value = v;
    last  = closes;
    do @(posedge clk); while (busy);
    track_element(v, closes);
  endtask

  task automatic drain_picks();
    @(negedge clk);
    start = 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
  endtask

  task automatic write_rank(input int unsigned r);
    drain_picks();
    repeat (8) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = r[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    rank_now = r;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = CNT_W'($urandom);
  endtask

  function automatic elem_t random_element();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return $urandom;
    if (pick < 9) return $signed($urandom_range(8)) - 4;
    case ($urandom_range(3))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  task automatic test_reset_rank_singletons();
    load_element(MOST_POS, 1'b1);
    load_element(MOST_NEG, 1'b1);
  endtask

  task automatic test_signed_extremes();
    write_rank(5);
    load_element(MOST_NEG, 1'b0);
    load_element(MOST_POS, 1'b0);
    load_element(0, 1'b0);
    load_element(-1, 1'b0);
    load_element(1, 1'b1);
  endtask

  task automatic test_duplicate_values();
    write_rank(3);
    load_element(7, 1'b0);
    load_element(7, 1'b0);
    load_element(-3, 1'b0);
    load_element(7, 1'b0);
    load_element(-3, 1'b0);
    load_element(7, 1'b1);
  endtask

  task automatic test_rank_out_of_range();
    write_rank(0);
    load_element(42, 1'b0);
    load_element(43, 1'b1);
    write_rank(MAX_RANK);
    load_element(1, 1'b0);
    load_element(2, 1'b0);
    load_element(3, 1'b1);
    write_rank(4);
    load_element(5, 1'b0);
    load_element(6, 1'b0);
    load_element(7, 1'b1);
  endtask

  task automatic test_random_sets(input int pct, input int budget);
    int          sent;
    int          n;
    int unsigned r;
    int unsigned sel;
    sent = 0;
    idle_pct = pct;
    while (sent < budget) begin
      n = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(80, 13);
      sel = $urandom_range(99);
      if (sel < 80) r = $urandom_range(n, 1);
      else if (sel < 88) r = n + 1;
      else if (sel < 93) r = 0;
      else r = $urandom_range(MAX_RANK, n + 1);
      if (r != rank_now || $urandom_range(3) == 0) write_rank(r);
      for (int i = 0; i < n; i++) load_element(random_element(), i == n - 1);
      sent += n;
    end
  endtask

  // Elements past the store's capacity must be dropped, but the last one still closes the set.
  task automatic test_store_overflow();
    idle_pct = 24;
    write_rank(MAX_ITEMS);
    for (int i = 0; i < MAX_ITEMS + 6; i++) load_element(random_element(), i == MAX_ITEMS + 5);
  endtask

  always @(posedge clk) begin : check_picks
    pick_t want;
    if (!rst && done) begin
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: selected=%0d bad_rank=%0b", selected, bad_rank);
      end else begin
        want = pending_picks.pop_front();
        if (selected !== want.selected || bad_rank !== want.bad_rank) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected selected=%0d bad_rank=%0b, got selected=%0d bad_rank=%0b",
                     want.selected, want.bad_rank, selected, bad_rank);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", idle_cycles);
      $display("FAIL kth_largest_select");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_rank_singletons();
    test_signed_extremes();
    test_duplicate_values();
    test_rank_out_of_range();
    test_random_sets(0, 60);
    test_random_sets(87, 60);
    test_random_sets(24, 60);
    test_store_overflow();
    drain_picks();
    repeat (64) @(posedge clk);
    mismatches += pending_picks.size();
    if (mismatches == 0) begin
      $display("PASS kth_largest_select");
    end else begin
      $display("FAIL kth_largest_select");
    end
    $finish;
  end

endmodule
